// ===== hdl/kvt_pkg.sv =====
// shared types and codes for the keyed variant table
`default_nettype none
package kvt_pkg;

  typedef enum logic [2:0] {
    OP_DISPATCH    = 3'd0,
    OP_REG_READY   = 3'd1,
    OP_REG_PENDING = 3'd2,
    OP_MARK_READY  = 3'd3,
    OP_REMOVE      = 3'd4,
    OP_ADD_RULE    = 3'd5,
    OP_CLEAR       = 3'd6,
    OP_QUERY       = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    OC_DIRECT   = 3'd0,
    OC_FALLBACK = 3'd1,
    OC_MISS     = 3'd2,
    OC_ACCEPTED = 3'd3,
    OC_REJECTED = 3'd4,
    OC_ABSENT   = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_MAX_ENTRIES  = 2'd0,
    CFG_MAX_RULES    = 2'd1,
    CFG_HIT_TRACKING = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] key;
    logic [63:0] target_key;
    logic [63:0] pso_handle;
  } item_t;

  typedef struct packed {
    logic [6:0] max_entries;
    logic [4:0] max_rules;
    logic       hit_tracking;
  } cfg_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] handle;
    logic        ready;
    logic [31:0] hits;
  } ent_t;

  typedef struct packed {
    logic [63:0] src;
    logic [63:0] dst;
  } rule_t;

endpackage
`default_nettype wire

// ===== hdl/kvt_front.sv =====
// input queue: takes beats and decodes the mode into an operation
`default_nettype none
module kvt_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    mode_i,
  input  wire logic [63:0]   key_i,
  input  wire logic [63:0]   target_key_i,
  input  wire logic [63:0]   pso_handle_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output kvt_pkg::item_t     pop_item_o
);
  import kvt_pkg::*;

  item_t      buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_item_o  = buf_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{op: op_e'(mode_i), key: key_i, target_key: target_key_i,
                       pso_handle: pso_handle_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/kvt_back.sv =====
// execution engine: entry and rule memories, lookup sweeps, counters, result register
`default_nettype none
module kvt_back #(
  parameter int TABLE_ENTRIES = 64,
  parameter int RULE_SLOTS    = 16,
  parameter int MAX_HOPS      = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire kvt_pkg::cfg_t  cfg_i,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire kvt_pkg::item_t pop_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [63:0]         handle_o,
  output logic [63:0]         resolved_key_o,
  output logic [2:0]          outcome_o,
  output logic                entry_ready_o,
  output logic                entry_pending_o,
  output logic [31:0]         entry_hits_o,
  output logic [31:0]         total_dispatches_o,
  output logic [31:0]         fallback_dispatches_o,
  output logic [31:0]         missed_dispatches_o,
  output logic [6:0]          ready_entries_o,
  output logic [6:0]          pending_entries_o,
  output logic [4:0]          rule_total_o
);
  import kvt_pkg::*;

  localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW  = (CW > 7) ? CW : 7;
  localparam int RIW   = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int RCW   = $clog2(RULE_SLOTS + 1);
  localparam int RCMPW = (RCW > 5) ? RCW : 5;
  localparam int HW    = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_KCHK, S_RULE, S_HCHK, S_DONE
  } state_e;

  state_e      state_q;
  item_t       item_q;
  logic [63:0] cur_q;
  logic        ret_hop_q;

  ent_t        ent_mem [TABLE_ENTRIES];
  rule_t       rule_mem [RULE_SLOTS];
  ent_t        rd_ent_q;
  rule_t       rd_rule_q;
  logic [IW-1:0]  ent_raddr;
  logic [RIW-1:0] rule_raddr;
  logic        ent_we_q, rule_we_q;
  logic [IW-1:0]  ent_waddr_q;
  logic [RIW-1:0] rule_waddr_q;
  ent_t        ent_wdata_q;
  rule_t       rule_wdata_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IW-1:0]  idx_q, pidx_q, f_slot_q, free_slot_q;
  logic        pend_q, pvalid_q, f_found_q, free_found_q;
  ent_t        f_ent_q;
  logic [RIW-1:0] r_q, rpidx_q;
  logic        rpend_q;
  logic [HW-1:0]  hop_q;

  logic [CW-1:0]  nready_q, npend_q, nvalid, reg_nr, reg_np;
  logic [RCW-1:0] rule_cnt_q;
  logic [31:0] disp_q, fb_q, miss_q;

  logic [63:0] res_handle_q, res_key_q;
  outcome_e    res_out_q;
  logic        res_rdy_q, res_pnd_q;
  logic [31:0] res_hits_q;

  logic [CMPW-1:0]  ent_lim, nvalid_x, nr_x, np_x;
  logic [RCMPW-1:0] rule_lim, rcnt_x;
  logic        ent_hit, last_ent, rule_hit, last_rule, reg_full, is_ready_op;
  logic [31:0] hits_inc;

  assign ent_raddr  = ({1'b0, idx_q} < (IW+1)'(TABLE_ENTRIES)) ? idx_q : '0;
  assign rule_raddr = ({1'b0, r_q} < (RIW+1)'(RULE_SLOTS)) ? r_q : '0;

  always_ff @(posedge clk_i) begin
    if (ent_we_q) ent_mem[ent_waddr_q] <= ent_wdata_q;
    rd_ent_q <= ent_mem[ent_raddr];
    if (rule_we_q) rule_mem[rule_waddr_q] <= rule_wdata_q;
    rd_rule_q <= rule_mem[rule_raddr];
  end

  always_comb begin
    nvalid    = nready_q + npend_q;
    nvalid_x  = CMPW'(nvalid);
    nr_x      = CMPW'(nready_q);
    np_x      = CMPW'(npend_q);
    rcnt_x    = RCMPW'(rule_cnt_q);
    ent_lim   = (CMPW'(cfg_i.max_entries) > CMPW'(TABLE_ENTRIES)) ?
                CMPW'(TABLE_ENTRIES) : CMPW'(cfg_i.max_entries);
    rule_lim  = (RCMPW'(cfg_i.max_rules) > RCMPW'(RULE_SLOTS)) ?
                RCMPW'(RULE_SLOTS) : RCMPW'(cfg_i.max_rules);
    ent_hit   = pend_q && pvalid_q && (rd_ent_q.key == cur_q);
    last_ent  = pend_q && (pidx_q == IW'(TABLE_ENTRIES - 1));
    rule_hit  = rpend_q && (rd_rule_q.src == cur_q);
    last_rule = rpend_q && (RCW'(rpidx_q) == rule_cnt_q - RCW'(1));
    reg_full  = (nvalid_x >= ent_lim) || (!f_found_q && !free_found_q);
    is_ready_op = (item_q.op == OP_REG_READY);
    reg_nr    = nready_q - CW'(f_found_q && f_ent_q.ready) + CW'(is_ready_op);
    reg_np    = npend_q - CW'(f_found_q && !f_ent_q.ready) + CW'(!is_ready_op);
    hits_inc  = f_ent_q.hits + 32'(cfg_i.hit_tracking);
  end

  assign pop_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      nready_q     <= '0;
      npend_q      <= '0;
      rule_cnt_q   <= '0;
      disp_q       <= '0;
      fb_q         <= '0;
      miss_q       <= '0;
      ent_we_q     <= 1'b0;
      rule_we_q    <= 1'b0;
      pend_q       <= 1'b0;
      rpend_q      <= 1'b0;
      out_valid_o  <= 1'b0;
      item_q       <= '0;
      cur_q        <= '0;
      ret_hop_q    <= 1'b0;
      idx_q        <= '0;
      pidx_q       <= '0;
      pvalid_q     <= 1'b0;
      f_found_q    <= 1'b0;
      f_slot_q     <= '0;
      f_ent_q      <= '0;
      free_found_q <= 1'b0;
      free_slot_q  <= '0;
      r_q          <= '0;
      rpidx_q      <= '0;
      hop_q        <= '0;
      ent_waddr_q  <= '0;
      ent_wdata_q  <= '0;
      rule_waddr_q <= '0;
      rule_wdata_q <= '0;
      res_handle_q <= '0;
      res_key_q    <= '0;
      res_out_q    <= OC_ACCEPTED;
      res_rdy_q    <= 1'b0;
      res_pnd_q    <= 1'b0;
      res_hits_q   <= '0;
      handle_o              <= '0;
      resolved_key_o        <= '0;
      outcome_o             <= '0;
      entry_ready_o         <= 1'b0;
      entry_pending_o       <= 1'b0;
      entry_hits_o          <= '0;
      total_dispatches_o    <= '0;
      fallback_dispatches_o <= '0;
      missed_dispatches_o   <= '0;
      ready_entries_o       <= '0;
      pending_entries_o     <= '0;
      rule_total_o          <= '0;
    end else begin
      ent_we_q  <= 1'b0;
      rule_we_q <= 1'b0;
      if (out_valid_o && out_ready_i && (state_q != S_DONE)) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            item_q       <= pop_item_i;
            cur_q        <= pop_item_i.key;
            ret_hop_q    <= 1'b0;
            idx_q        <= '0;
            pend_q       <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_FIND;
          end
        end
        S_FIND: begin
          pvalid_q <= valid_q[ent_raddr];
          if (pend_q && !pvalid_q && !free_found_q) begin
            free_found_q <= 1'b1;
            free_slot_q  <= pidx_q;
          end
          if (ent_hit || last_ent) begin
            f_found_q <= ent_hit;
            f_slot_q  <= pidx_q;
            f_ent_q   <= rd_ent_q;
            pend_q    <= 1'b0;
            state_q   <= ret_hop_q ? S_HCHK : S_KCHK;
          end else begin
            pend_q <= 1'b1;
            pidx_q <= idx_q;
            idx_q  <= idx_q + IW'(1);
          end
        end
        S_KCHK: begin
          res_handle_q <= '0;
          res_key_q    <= item_q.key;
          res_out_q    <= OC_ACCEPTED;
          res_rdy_q    <= f_found_q && f_ent_q.ready;
          res_pnd_q    <= f_found_q && !f_ent_q.ready;
          res_hits_q   <= f_found_q ? f_ent_q.hits : 32'd0;
          state_q      <= S_DONE;
          unique case (item_q.op)
            OP_DISPATCH: begin
              disp_q <= disp_q + 32'd1;
              if (f_found_q && f_ent_q.ready) begin
                ent_we_q     <= 1'b1;
                ent_waddr_q  <= f_slot_q;
                ent_wdata_q  <= '{key: f_ent_q.key, handle: f_ent_q.handle, ready: 1'b1,
                                  hits: hits_inc};
                res_handle_q <= f_ent_q.handle;
                res_key_q    <= f_ent_q.key;
                res_out_q    <= OC_DIRECT;
                res_hits_q   <= hits_inc;
              end else if (rule_cnt_q == '0) begin
                miss_q    <= miss_q + 32'd1;
                res_out_q <= OC_MISS;
              end else begin
                hop_q   <= '0;
                r_q     <= '0;
                rpend_q <= 1'b0;
                state_q <= S_RULE;
              end
            end
            OP_REG_READY, OP_REG_PENDING: begin
              if (reg_full) begin
                res_out_q <= OC_REJECTED;
              end else begin
                ent_we_q    <= 1'b1;
                ent_waddr_q <= f_found_q ? f_slot_q : free_slot_q;
                ent_wdata_q <= '{key: item_q.key,
                                 handle: is_ready_op ? item_q.pso_handle : 64'd0,
                                 ready: is_ready_op, hits: 32'd0};
                valid_q[f_found_q ? f_slot_q : free_slot_q] <= 1'b1;
                nready_q    <= reg_nr;
                npend_q     <= reg_np;
                res_rdy_q   <= is_ready_op;
                res_pnd_q   <= !is_ready_op;
                res_hits_q  <= 32'd0;
              end
            end
            OP_MARK_READY: begin
              if (f_found_q) begin
                ent_we_q    <= 1'b1;
                ent_waddr_q <= f_slot_q;
                ent_wdata_q <= '{key: f_ent_q.key, handle: item_q.pso_handle, ready: 1'b1,
                                 hits: f_ent_q.hits};
                if (!f_ent_q.ready) begin
                  nready_q <= nready_q + CW'(1);
                  npend_q  <= npend_q - CW'(1);
                end
                res_rdy_q <= 1'b1;
                res_pnd_q <= 1'b0;
              end else begin
                res_out_q <= OC_ABSENT;
              end
            end
            OP_REMOVE: begin
              if (f_found_q) begin
                valid_q[f_slot_q] <= 1'b0;
                if (f_ent_q.ready) nready_q <= nready_q - CW'(1);
                else npend_q <= npend_q - CW'(1);
                res_rdy_q  <= 1'b0;
                res_pnd_q  <= 1'b0;
                res_hits_q <= 32'd0;
              end else begin
                res_out_q <= OC_ABSENT;
              end
            end
            OP_ADD_RULE: begin
              if (rcnt_x >= rule_lim) begin
                res_out_q <= OC_REJECTED;
              end else begin
                rule_we_q    <= 1'b1;
                rule_waddr_q <= RIW'(rule_cnt_q);
                rule_wdata_q <= '{src: item_q.key, dst: item_q.target_key};
                rule_cnt_q   <= rule_cnt_q + RCW'(1);
              end
            end
            OP_CLEAR: begin
              valid_q    <= '0;
              nready_q   <= '0;
              npend_q    <= '0;
              rule_cnt_q <= '0;
              disp_q     <= '0;
              fb_q       <= '0;
              miss_q     <= '0;
              res_rdy_q  <= 1'b0;
              res_pnd_q  <= 1'b0;
              res_hits_q <= 32'd0;
            end
            OP_QUERY: begin
              if (!f_found_q) res_out_q <= OC_ABSENT;
            end
            default: begin
              res_out_q <= OC_ABSENT;
            end
          endcase
        end
        S_RULE: begin
          if (rule_hit) begin
            cur_q        <= rd_rule_q.dst;
            rpend_q      <= 1'b0;
            ret_hop_q    <= 1'b1;
            idx_q        <= '0;
            pend_q       <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_FIND;
          end else if (last_rule) begin
            rpend_q   <= 1'b0;
            miss_q    <= miss_q + 32'd1;
            res_out_q <= OC_MISS;
            state_q   <= S_DONE;
          end else begin
            rpend_q <= 1'b1;
            rpidx_q <= r_q;
            r_q     <= r_q + RIW'(1);
          end
        end
        S_HCHK: begin
          if (f_found_q && f_ent_q.ready && (cur_q != item_q.key)) begin
            ent_we_q     <= 1'b1;
            ent_waddr_q  <= f_slot_q;
            ent_wdata_q  <= '{key: f_ent_q.key, handle: f_ent_q.handle, ready: 1'b1,
                              hits: hits_inc};
            fb_q         <= fb_q + 32'd1;
            res_handle_q <= f_ent_q.handle;
            res_key_q    <= f_ent_q.key;
            res_out_q    <= OC_FALLBACK;
            state_q      <= S_DONE;
          end else if (hop_q == HW'(MAX_HOPS - 1)) begin
            miss_q    <= miss_q + 32'd1;
            res_out_q <= OC_MISS;
            state_q   <= S_DONE;
          end else begin
            hop_q   <= hop_q + HW'(1);
            r_q     <= '0;
            rpend_q <= 1'b0;
            state_q <= S_RULE;
          end
        end
        S_DONE: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o           <= 1'b1;
            handle_o              <= res_handle_q;
            resolved_key_o        <= res_key_q;
            outcome_o             <= res_out_q;
            entry_ready_o         <= res_rdy_q;
            entry_pending_o       <= res_pnd_q;
            entry_hits_o          <= res_hits_q;
            total_dispatches_o    <= disp_q;
            fallback_dispatches_o <= fb_q;
            missed_dispatches_o   <= miss_q;
            ready_entries_o       <= nr_x[6:0];
            pending_entries_o     <= np_x[6:0];
            rule_total_o          <= rcnt_x[4:0];
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/keyed_variant_table_with_fallback.sv =====
// top level of the keyed variant table with fallback rules
//
// One beat in gives one beat out. The front queue holds two items; the engine
// works on one item at a time. Every item starts with a linear sweep of the
// entry memory that stops at the entry holding its key; for an absent key the
// sweep runs to the last slot. A dispatch that misses its direct entry walks
// up to MAX_HOPS hops, each a sweep of the rule memory, another entry sweep
// and a check step. A stalled result beat holds the engine in its done state.
// Configuration writes are taken in any cycle and belong to idle periods.
`default_nettype none
module keyed_variant_table_with_fallback #(
  parameter int TABLE_ENTRIES = 64,
  parameter int RULE_SLOTS    = 16,
  parameter int MAX_HOPS      = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [6:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    mode_i,
  input  wire logic [63:0]   key_i,
  input  wire logic [63:0]   target_key_i,
  input  wire logic [63:0]   pso_handle_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [63:0]        handle_o,
  output logic [63:0]        resolved_key_o,
  output logic [2:0]         outcome_o,
  output logic               entry_ready_o,
  output logic               entry_pending_o,
  output logic [31:0]        entry_hits_o,
  output logic [31:0]        total_dispatches_o,
  output logic [31:0]        fallback_dispatches_o,
  output logic [31:0]        missed_dispatches_o,
  output logic [6:0]         ready_entries_o,
  output logic [6:0]         pending_entries_o,
  output logic [4:0]         rule_total_o
);
  import kvt_pkg::*;

  cfg_t  cfg_q;
  item_t pop_item;
  logic  pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_entries: 7'd64, max_rules: 5'd16, hit_tracking: 1'b1};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_ENTRIES:  cfg_q.max_entries  <= cfg_data_i;
        CFG_MAX_RULES:    cfg_q.max_rules    <= cfg_data_i[4:0];
        CFG_HIT_TRACKING: cfg_q.hit_tracking <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  kvt_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .key_i,
    .target_key_i,
    .pso_handle_i,
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  kvt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .RULE_SLOTS    (RULE_SLOTS),
    .MAX_HOPS      (MAX_HOPS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o,
    .out_ready_i,
    .handle_o,
    .resolved_key_o,
    .outcome_o,
    .entry_ready_o,
    .entry_pending_o,
    .entry_hits_o,
    .total_dispatches_o,
    .fallback_dispatches_o,
    .missed_dispatches_o,
    .ready_entries_o,
    .pending_entries_o,
    .rule_total_o
  );

endmodule
`default_nettype wire

// ===== tb/tb_keyed_variant_table_with_fallback.sv =====
// self-checking testbench for the keyed variant table with fallback rules
`default_nettype none
module tb_keyed_variant_table_with_fallback;
  timeunit 1ns;
  timeprecision 1ps;
  import kvt_pkg::*;

  localparam int NSLOT = 64;
  localparam int NRULE = 16;
  localparam int NHOP = 8;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [63:0] handle;
    logic [63:0] resolved_key;
    logic [2:0]  outcome;
    logic        entry_ready;
    logic        entry_pending;
    logic [31:0] entry_hits;
    logic [31:0] total_disp;
    logic [31:0] fb_disp;
    logic [31:0] miss_disp;
    logic [6:0]  n_ready;
    logic [6:0]  n_pending;
    logic [4:0]  n_rules;
  } answer_t;

  class variant_table_scoreboard;
    bit          valid_q[NSLOT];
    logic [63:0] key_q[NSLOT];
    logic [63:0] handle_q[NSLOT];
    bit          ready_q[NSLOT];
    logic [31:0] hits_q[NSLOT];
    logic [63:0] from_q[NRULE];
    logic [63:0] to_q[NRULE];
    int          rules;
    logic [31:0] n_disp, n_fb, n_miss;
    int          cap_entries, cap_rules;
    bit          track;
    answer_t     pending_answers[$];
    int          errors;
    int          checked;
    int          op_seen[8];
    int          oc_seen[8];

    function new();
      cap_entries = 64;
      cap_rules = 16;
      track = 1;
      wipe();
    endfunction

    function void wipe();
      foreach (valid_q[i]) valid_q[i] = 0;
      rules = 0;
      n_disp = 0;
      n_fb = 0;
      n_miss = 0;
    endfunction

    function int lookup(logic [63:0] k);
      for (int i = 0; i < NSLOT; i++)
        if (valid_q[i] && key_q[i] == k) return i;
      return -1;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (valid_q[i]) if (valid_q[i]) n++;
      return n;
    endfunction

    function outcome_e store(logic [63:0] k, logic [63:0] h, bit rdy);
      int lim, s;
      lim = (cap_entries > NSLOT) ? NSLOT : cap_entries;
      if (occupancy() >= lim) return OC_REJECTED;
      s = lookup(k);
      if (s < 0)
        for (int i = 0; i < NSLOT; i++)
          if (!valid_q[i]) begin
            s = i;
            break;
          end
      if (s < 0) return OC_REJECTED;
      valid_q[s] = 1;
      key_q[s] = k;
      handle_q[s] = h;
      ready_q[s] = rdy;
      hits_q[s] = 0;
      return OC_ACCEPTED;
    endfunction

    function int walk(logic [63:0] k, output bit via);
      int s;
      logic [63:0] cur;
      bit found;
      via = 0;
      s = lookup(k);
      cur = k;
      if (s >= 0 && ready_q[s]) return s;
      for (int hop = 0; hop < NHOP; hop++) begin
        found = 0;
        for (int r = 0; r < rules; r++)
          if (from_q[r] == cur) begin
            cur = to_q[r];
            found = 1;
            s = lookup(cur);
            if (s >= 0 && ready_q[s] && cur != k) begin
              via = 1;
              return s;
            end
            break;
          end
        if (!found) break;
      end
      return -1;
    endfunction

    function void note_item(op_e op, logic [63:0] k, logic [63:0] tk, logic [63:0] h);
      answer_t a;
      int s, lim;
      bit via;
      a = '0;
      a.resolved_key = k;
      a.outcome = OC_ACCEPTED;
      op_seen[op]++;
      case (op)
        OP_DISPATCH: begin
          n_disp++;
          s = walk(k, via);
          if (s >= 0) begin
            if (track) hits_q[s]++;
            if (via) n_fb++;
            a.handle = handle_q[s];
            a.resolved_key = key_q[s];
            a.outcome = via ? OC_FALLBACK : OC_DIRECT;
          end else begin
            n_miss++;
            a.outcome = OC_MISS;
          end
        end
        OP_REG_READY: a.outcome = store(k, h, 1);
        OP_REG_PENDING: a.outcome = store(k, '0, 0);
        OP_MARK_READY: begin
          s = lookup(k);
          if (s >= 0) begin
            handle_q[s] = h;
            ready_q[s] = 1;
          end else a.outcome = OC_ABSENT;
        end
        OP_REMOVE: begin
          s = lookup(k);
          if (s >= 0) valid_q[s] = 0;
          else a.outcome = OC_ABSENT;
        end
        OP_ADD_RULE: begin
          lim = (cap_rules > NRULE) ? NRULE : cap_rules;
          if (rules >= lim) a.outcome = OC_REJECTED;
          else begin
            from_q[rules] = k;
            to_q[rules] = tk;
            rules++;
          end
        end
        OP_CLEAR: wipe();
        default: if (lookup(k) < 0) a.outcome = OC_ABSENT;
      endcase
      foreach (valid_q[i])
        if (valid_q[i]) begin
          if (ready_q[i]) a.n_ready++;
          else a.n_pending++;
        end
      s = lookup(k);
      if (s >= 0) begin
        a.entry_ready = ready_q[s];
        a.entry_pending = !ready_q[s];
        a.entry_hits = hits_q[s];
      end
      a.total_disp = n_disp;
      a.fb_disp = n_fb;
      a.miss_disp = n_miss;
      a.n_rules = rules[4:0];
      oc_seen[a.outcome]++;
      pending_answers.insert(pending_answers.size(), a);
    endfunction

    function void check_beat(answer_t got);
      answer_t e;
      checked++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat %p", $realtime, got);
        errors++;
        return;
      end
      e = pending_answers.pop_front();
      if (got !== e) begin
        errors++;
        $display("%0t: mismatch", $realtime);
        if (got.handle !== e.handle)
          $display("  handle exp %h got %h", e.handle, got.handle);
        if (got.resolved_key !== e.resolved_key)
          $display("  resolved_key exp %h got %h", e.resolved_key, got.resolved_key);
        if (got.outcome !== e.outcome)
          $display("  outcome exp %0d got %0d", e.outcome, got.outcome);
        if (got.entry_ready !== e.entry_ready)
          $display("  entry_ready exp %0d got %0d", e.entry_ready, got.entry_ready);
        if (got.entry_pending !== e.entry_pending)
          $display("  entry_pending exp %0d got %0d", e.entry_pending, got.entry_pending);
        if (got.entry_hits !== e.entry_hits)
          $display("  entry_hits exp %0d got %0d", e.entry_hits, got.entry_hits);
        if (got.total_disp !== e.total_disp)
          $display("  total_dispatches exp %0d got %0d", e.total_disp, got.total_disp);
        if (got.fb_disp !== e.fb_disp)
          $display("  fallback_dispatches exp %0d got %0d", e.fb_disp, got.fb_disp);
        if (got.miss_disp !== e.miss_disp)
          $display("  missed_dispatches exp %0d got %0d", e.miss_disp, got.miss_disp);
        if (got.n_ready !== e.n_ready)
          $display("  ready_entries exp %0d got %0d", e.n_ready, got.n_ready);
        if (got.n_pending !== e.n_pending)
          $display("  pending_entries exp %0d got %0d", e.n_pending, got.n_pending);
        if (got.n_rules !== e.n_rules)
          $display("  rule_total exp %0d got %0d", e.n_rules, got.n_rules);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic [1:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic [2:0] mode_i = '0;
  logic [63:0] key_i = '0, target_key_i = '0, pso_handle_i = '0;
  logic out_ready_i = 0;
  logic cfg_ready_o, in_ready_o, out_valid_o;
  answer_t got_w;

  keyed_variant_table_with_fallback u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .key_i, .target_key_i, .pso_handle_i,
    .out_valid_o, .out_ready_i,
    .handle_o(got_w.handle), .resolved_key_o(got_w.resolved_key),
    .outcome_o(got_w.outcome), .entry_ready_o(got_w.entry_ready),
    .entry_pending_o(got_w.entry_pending), .entry_hits_o(got_w.entry_hits),
    .total_dispatches_o(got_w.total_disp), .fallback_dispatches_o(got_w.fb_disp),
    .missed_dispatches_o(got_w.miss_disp), .ready_entries_o(got_w.n_ready),
    .pending_entries_o(got_w.n_pending), .rule_total_o(got_w.n_rules)
  );

  variant_table_scoreboard sb = new();
  int idle_cycles = 0;
  bit sink_hold = 0;
  bit flood_done = 0;
  int sent = 0;
  logic [63:0] key_pool[16];

  initial forever #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(got_w);
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (sink_hold) begin
        out_ready_i <= 0;
        repeat (3000) @(posedge clk_i);
        sink_hold = 0;
      end
      g = (sent < 300 || sent > 1400) ? 0 : pick_gap();
      if (g > 0) begin
        out_ready_i <= 0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
    end
  end

  // watchdog on acceptance activity
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(op_e op, logic [63:0] k, logic [63:0] tk, logic [63:0] h,
                           bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= op;
    key_i <= k;
    target_key_i <= tk;
    pso_handle_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, k, tk, h);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [6:0] v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    case (idx)
      CFG_MAX_ENTRIES: sb.cap_entries = v;
      CFG_MAX_RULES: sb.cap_rules = v[4:0];
      default: sb.track = v[0];
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_key();
    return ($urandom_range(0, 19) == 0) ? rnd64() : key_pool[$urandom_range(0, 15)];
  endfunction

  task automatic random_item(bit gaps);
    int r;
    op_e op;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_DISPATCH;
    else if (r < 50) op = OP_REG_READY;
    else if (r < 60) op = OP_REG_PENDING;
    else if (r < 70) op = OP_MARK_READY;
    else if (r < 78) op = OP_REMOVE;
    else if (r < 90) op = OP_ADD_RULE;
    else if (r < 91) op = OP_CLEAR;
    else op = OP_QUERY;
    send_item(op, pool_key(), pool_key(), rnd64(), gaps);
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = rnd64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, every op and the corner behaviors
    send_item(OP_DISPATCH, '0, '0, '0, 0);
    send_item(OP_QUERY, '1, '0, '0, 0);
    send_item(OP_MARK_READY, 64'h5, '0, '1, 0);
    send_item(OP_REMOVE, 64'h5, '0, '0, 0);
    send_item(OP_REG_READY, '1, '0, '1, 0);
    send_item(OP_REG_PENDING, '0, '0, '1, 0);
    send_item(OP_DISPATCH, '1, '0, '0, 0);
    send_item(OP_DISPATCH, '0, '0, '0, 0);
    send_item(OP_ADD_RULE, '0, 64'h22, '0, 0);
    send_item(OP_ADD_RULE, 64'h22, '1, '0, 0);
    send_item(OP_DISPATCH, '0, '0, '0, 0);
    send_item(OP_ADD_RULE, 64'h33, '0, '0, 0);
    send_item(OP_ADD_RULE, '0, 64'h33, '0, 0);
    send_item(OP_DISPATCH, 64'h33, '0, '0, 0);
    send_item(OP_MARK_READY, '0, '0, 64'hA5A5, 0);
    send_item(OP_DISPATCH, 64'h33, '0, '0, 0);
    send_item(OP_REG_READY, '1, '0, 64'h77, 0);
    send_item(OP_QUERY, '1, '0, '0, 0);
    send_item(OP_REMOVE, '1, '0, '0, 0);
    send_item(OP_DISPATCH, 64'h22, '0, '0, 0);
    send_item(OP_CLEAR, '0, '0, '0, 0);
    send_item(OP_QUERY, '0, '0, '0, 0);
    drain();

    // small capacities, tracking off
    write_reg(CFG_MAX_ENTRIES, 7'd0);
    write_reg(CFG_MAX_RULES, 7'd0);
    write_reg(CFG_HIT_TRACKING, 7'd0);
    for (int i = 0; i < 60; i++) random_item(1);
    drain();
    write_reg(CFG_MAX_ENTRIES, 7'd3);
    write_reg(CFG_MAX_RULES, 7'd2);
    for (int i = 0; i < 300; i++) random_item(1);
    drain();

    // fill the whole table past its limit, with hit tracking on
    write_reg(CFG_MAX_ENTRIES, 7'd127);
    write_reg(CFG_MAX_RULES, 7'd31);
    write_reg(CFG_HIT_TRACKING, 7'd1);
    send_item(OP_CLEAR, '0, '0, '0, 0);
    for (int i = 0; i < 66; i++) send_item(OP_REG_READY, rnd64(), '0, rnd64(), 0);
    for (int i = 0; i < 18; i++)
      send_item(OP_ADD_RULE, pool_key(), pool_key(), '0, 0);
    // long sink hold-off while the source keeps offering
    sink_hold = 1;
    for (int i = 0; i < 40; i++) random_item(0);
    send_item(OP_CLEAR, '0, '0, '0, 0);
    drain();

    // main random body with default-like settings
    write_reg(CFG_MAX_ENTRIES, 7'd64);
    write_reg(CFG_MAX_RULES, 7'd16);
    for (int i = 0; i < 600; i++) random_item(1);
    drain();
    write_reg(CFG_MAX_ENTRIES, 7'd10);
    write_reg(CFG_MAX_RULES, 7'd5);
    write_reg(CFG_HIT_TRACKING, 7'd0);
    for (int i = 0; i < 300; i++) random_item(1);
    drain();
    write_reg(CFG_HIT_TRACKING, 7'd1);
    for (int i = 0; i < 250; i++) random_item(i % 50 > 25);
    drain();

    $display("ran %0d items, %0d result beats checked", sent, sb.checked);
    $display("ops seen d%0d rr%0d rp%0d mr%0d rm%0d ar%0d cl%0d q%0d; hits d%0d fb%0d miss%0d",
             sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3],
             sb.op_seen[4], sb.op_seen[5], sb.op_seen[6], sb.op_seen[7],
             sb.oc_seen[0], sb.oc_seen[1], sb.oc_seen[2]);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
